/* rtl/core/dpm_pkg.sv */
// Shared types, constants and the square root step of the distance projection map.
package dpm_pkg;

  // Field widths and fixed point layout
  localparam int MAX_SIDE  = 4096;
  localparam int SIDE_W    = 13;
  localparam int CTR_W     = 16;
  localparam int PIX_W     = 12;
  localparam int FRAC      = 4;
  localparam int PROJ_W    = 16;
  localparam int STAT_W    = 2;
  localparam int APB_W     = 32;
  localparam int NUM_REGS  = 4;
  localparam int PADDR_W   = $clog2(4 * NUM_REGS);

  localparam int H_RESET   = 480;
  localparam int W_RESET   = 640;

  // Corner and pixel distance arithmetic
  localparam int CPOS_W    = SIDE_W + FRAC;
  localparam int PDIF_W    = (PIX_W + FRAC > CTR_W) ? PIX_W + FRAC : CTR_W;
  localparam int RAD_W     = 2 * CPOS_W + 1;
  localparam int RES_W     = RAD_W + 1;
  localparam int ROOT_W    = CPOS_W + 1;
  localparam int SQ_STG    = (ROOT_W + 1) / 2;
  localparam logic [RES_W-1:0] SQ_TOP_BIT = RES_W'(1) << (2 * (ROOT_W - 1));

  // Quotient and saturation
  localparam int ONE_SHIFT = 14;
  localparam int ONE_Q14   = 1 << ONE_SHIFT;
  localparam int SAT_Q     = ONE_Q14 + 32768;
  localparam int LIM_MUL   = SAT_Q + 1;
  localparam int Q_W       = 16;
  localparam int DV_STG    = Q_W / 2;
  localparam int NUM_W     = ROOT_W + ONE_SHIFT + 1;
  localparam int LIM_W     = ROOT_W + $clog2(LIM_MUL);
  localparam logic [PROJ_W-1:0] PROJ_MIN = {1'b1, {(PROJ_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_HEIGHT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_CROW   = 2'd2,
    REG_CCOL   = 2'd3
  } cfg_reg_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    NS_IDLE,
    NS_SQUARE,
    NS_SUM,
    NS_ROOT,
    NS_MIN,
    NS_LIMIT
  } norm_state_e;

  // Configuration seen by the datapath
  typedef struct packed {
    logic              hold;
    logic [CTR_W-1:0]  center_row;
    logic [CTR_W-1:0]  center_col;
    logic [ROOT_W-1:0] norm;
    logic [LIM_W-1:0]  lim;
  } norm_info_t;

  // Remainder and partial root of the digit-by-digit square root
  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [RES_W-1:0] res;
  } sq_acc_t;

  // One result bit of the square root; bitv is the current power of four
  function automatic sq_acc_t sqrt_step(sq_acc_t a, logic [RES_W-1:0] bitv);
    sq_acc_t          o;
    logic [RES_W-1:0] t;
    t = a.res + bitv;
    if ({1'b0, a.rem} >= t) begin
      o.rem = RAD_W'({1'b0, a.rem} - t);
      o.res = (a.res >> 1) + bitv;
    end else begin
      o.rem = a.rem;
      o.res = a.res >> 1;
    end
    return o;
  endfunction

endpackage

/* rtl/core/dpm_norm.sv */
// Configuration registers and the sequencer for the nearest corner distance.
module dpm_norm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpm_pkg::PADDR_W-1:0]   paddr,
  input  logic [dpm_pkg::APB_W-1:0]     pwdata,
  output logic [dpm_pkg::APB_W-1:0]     prdata,
  output logic                          pready,
  output dpm_pkg::norm_info_t           info_o
);
  import dpm_pkg::*;

  logic [SIDE_W-1:0] height_q, width_q;
  logic [CTR_W-1:0]  crow_q, ccol_q;
  logic              wr;
  cfg_reg_e          reg_sel;

  norm_state_e       state_q, state_d;
  logic [1:0]        idx_q, idx_d;
  logic [2*CPOS_W-1:0] sr_q, sr_d, sc_q, sc_d;
  sq_acc_t           acc_q, acc_d;
  logic [RES_W-1:0]  bit_q, bit_d;
  logic [ROOT_W-1:0] min_q, min_d, norm_q, norm_d;
  logic [LIM_W-1:0]  lim_q, lim_d;

  logic [SIDE_W-1:0] hc, wc;
  logic [CPOS_W-1:0] rpos, cpos, dr, dc;
  logic [ROOT_W-1:0] root, newmin;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_sel = cfg_reg_e'(paddr[PADDR_W-1:2]);

  // Register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= SIDE_W'(H_RESET);
      width_q  <= SIDE_W'(W_RESET);
      crow_q   <= '0;
      ccol_q   <= '0;
    end else if (wr) begin
      case (reg_sel)
        REG_HEIGHT: height_q <= pwdata[SIDE_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[SIDE_W-1:0];
        REG_CROW:   crow_q   <= pwdata[CTR_W-1:0];
        REG_CCOL:   ccol_q   <= pwdata[CTR_W-1:0];
        default:    ;
      endcase
    end
  end

  // Register read
  always_comb begin
    case (reg_sel)
      REG_HEIGHT: prdata = APB_W'(height_q);
      REG_WIDTH:  prdata = APB_W'(width_q);
      REG_CROW:   prdata = APB_W'(crow_q);
      REG_CCOL:   prdata = APB_W'(ccol_q);
      default:    prdata = '0;
    endcase
  end

  // Corner position: corners visited as (0,0), (0,W), (H,W), (H,0)
  assign hc   = (int'(height_q) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : height_q;
  assign wc   = (int'(width_q) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : width_q;
  assign rpos = idx_q[1] ? {hc, {FRAC{1'b0}}} : '0;
  assign cpos = (idx_q[0] ^ idx_q[1]) ? {wc, {FRAC{1'b0}}} : '0;
  assign dr   = (rpos > CPOS_W'(crow_q)) ? rpos - CPOS_W'(crow_q) : CPOS_W'(crow_q) - rpos;
  assign dc   = (cpos > CPOS_W'(ccol_q)) ? cpos - CPOS_W'(ccol_q) : CPOS_W'(ccol_q) - cpos;
  assign root = acc_q.res[ROOT_W-1:0];
  assign newmin = (idx_q == 2'd0 || root < min_q) ? root : min_q;

  // Sequencer: square, sum, one root bit per cycle, running minimum
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    sr_d    = sr_q;
    sc_d    = sc_q;
    acc_d   = acc_q;
    bit_d   = bit_q;
    min_d   = min_q;
    norm_d  = norm_q;
    lim_d   = lim_q;
    case (state_q)
      NS_IDLE: ;
      NS_SQUARE: begin
        sr_d    = (2*CPOS_W)'(dr) * (2*CPOS_W)'(dr);
        sc_d    = (2*CPOS_W)'(dc) * (2*CPOS_W)'(dc);
        state_d = NS_SUM;
      end
      NS_SUM: begin
        acc_d.rem = RAD_W'(sr_q) + RAD_W'(sc_q);
        acc_d.res = '0;
        bit_d     = SQ_TOP_BIT;
        state_d   = NS_ROOT;
      end
      NS_ROOT: begin
        acc_d = sqrt_step(acc_q, bit_q);
        bit_d = bit_q >> 2;
        if (bit_q == RES_W'(1)) begin
          state_d = NS_MIN;
        end
      end
      NS_MIN: begin
        min_d = newmin;
        if (idx_q == 2'd3) begin
          norm_d  = newmin;
          state_d = NS_LIMIT;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = NS_SQUARE;
        end
      end
      NS_LIMIT: begin
        lim_d   = LIM_W'(norm_q) * LIM_W'(LIM_MUL);
        state_d = NS_IDLE;
      end
      default: state_d = NS_IDLE;
    endcase
    // any write restarts the corner sweep with the new values
    if (wr) begin
      state_d = NS_SQUARE;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NS_IDLE;
      idx_q   <= '0;
      norm_q  <= '0;
      lim_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      norm_q  <= norm_d;
      lim_q   <= lim_d;
    end
  end

  // Datapath of the sequencer
  always_ff @(posedge clk_i) begin
    sr_q  <= sr_d;
    sc_q  <= sc_d;
    acc_q <= acc_d;
    bit_q <= bit_d;
    min_q <= min_d;
  end

  assign info_o.hold       = (state_q != NS_IDLE) | wr;
  assign info_o.center_row = crow_q;
  assign info_o.center_col = ccol_q;
  assign info_o.norm       = norm_q;
  assign info_o.lim        = lim_q;

endmodule

/* rtl/core/dpm_dist.sv */
// Pixel distance pipeline: offsets, squares, sum and a staged square root.
module dpm_dist (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [dpm_pkg::PIX_W-1:0]    pixel_row_i,
  input  logic [dpm_pkg::PIX_W-1:0]    pixel_col_i,
  input  dpm_pkg::norm_info_t          info_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dpm_pkg::ROOT_W-1:0]   dist_o
);
  import dpm_pkg::*;

  localparam int NST = 3 + SQ_STG;

  logic [NST-1:0]      v_q, vin, rdy;
  logic [PDIF_W-1:0]   pr, pc, dr_q, dc_q;
  logic [2*PDIF_W-1:0] sr_q, sc_q;
  sq_acc_t             acc_q [0:SQ_STG];

  // A stage may load when it or any later stage holds a bubble, or when the output is not stalled
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = ~(&v_q[NST-1:k]) | ~out_stall_i;
  end

  assign vin        = {v_q[NST-2:0], in_valid_i};
  assign in_stall_o = ~rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= vin[k];
      end
    end
  end

  // Stage 0: absolute offsets from the center in Q.4
  assign pr = PDIF_W'({pixel_row_i, {FRAC{1'b0}}});
  assign pc = PDIF_W'({pixel_col_i, {FRAC{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      dr_q <= (pr > PDIF_W'(info_i.center_row)) ? pr - PDIF_W'(info_i.center_row)
                                                : PDIF_W'(info_i.center_row) - pr;
      dc_q <= (pc > PDIF_W'(info_i.center_col)) ? pc - PDIF_W'(info_i.center_col)
                                                : PDIF_W'(info_i.center_col) - pc;
    end
  end

  // Stage 1: squares
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      sr_q <= (2*PDIF_W)'(dr_q) * (2*PDIF_W)'(dr_q);
      sc_q <= (2*PDIF_W)'(dc_q) * (2*PDIF_W)'(dc_q);
    end
  end

  // Stage 2: sum of squares starts the root
  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      acc_q[0].rem <= RAD_W'(sr_q) + RAD_W'(sc_q);
      acc_q[0].res <= '0;
    end
  end

  // Root stages: two result bits each
  for (genvar j = 0; j < SQ_STG; j++) begin : g_root
    localparam logic [RES_W-1:0] B0 = SQ_TOP_BIT >> (4 * j);
    sq_acc_t s0, nxt;
    assign s0 = sqrt_step(acc_q[j], B0);
    if (2 * j + 1 < ROOT_W) begin : g_two
      localparam logic [RES_W-1:0] B1 = SQ_TOP_BIT >> (4 * j + 2);
      assign nxt = sqrt_step(s0, B1);
    end else begin : g_one
      assign nxt = s0;
    end
    always_ff @(posedge clk_i) begin
      if (rdy[3 + j]) acc_q[j + 1] <= nxt;
    end
  end

  assign out_valid_o = v_q[NST-1];
  assign dist_o      = acc_q[SQ_STG].res[ROOT_W-1:0];

endmodule

/* rtl/core/dpm_div.sv */
// Quotient pipeline: rounded distance over normalizer, saturation and result register.
module dpm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [dpm_pkg::ROOT_W-1:0]   dist_i,
  input  dpm_pkg::norm_info_t          info_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dpm_pkg::PROJ_W-1:0]   projection_o,
  output logic [dpm_pkg::STAT_W-1:0]   status_o
);
  import dpm_pkg::*;

  localparam int NST = DV_STG + 2;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
    logic             sat;
  } div_acc_t;

  logic [NST-1:0]    v_q, vin, rdy;
  div_acc_t          dacc_q [0:DV_STG];
  logic [NUM_W-1:0]  num;
  logic [PROJ_W-1:0] proj_q;
  status_e           status_q;
  logic [Q_W:0]      diff;

  // One restoring division step at quotient bit i
  function automatic div_acc_t div_step(div_acc_t a, logic [ROOT_W-1:0] n, int i);
    div_acc_t         o;
    logic [NUM_W:0]   trial;
    o     = a;
    trial = (NUM_W+1)'(n) << i;
    if ({1'b0, a.rem} >= trial) begin
      o.rem    = NUM_W'({1'b0, a.rem} - trial);
      o.quo[i] = 1'b1;
    end
    return o;
  endfunction

  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = ~(&v_q[NST-1:k]) | ~out_stall_i;
  end

  assign vin        = {v_q[NST-2:0], in_valid_i};
  assign in_stall_o = ~rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= vin[k];
      end
    end
  end

  // Stage 0: numerator with half the divisor added; saturation by limit compare
  assign num = (NUM_W'(dist_i) << ONE_SHIFT) + NUM_W'(info_i.norm >> 1);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      dacc_q[0].rem <= num;
      dacc_q[0].quo <= '0;
      dacc_q[0].sat <= (LIM_W'(num) >= info_i.lim);
    end
  end

  // Division stages: two quotient bits each, most significant first
  for (genvar j = 0; j < DV_STG; j++) begin : g_div
    div_acc_t s0, nxt;
    assign s0  = div_step(dacc_q[j], info_i.norm, Q_W - 1 - 2 * j);
    assign nxt = div_step(s0, info_i.norm, Q_W - 2 - 2 * j);
    always_ff @(posedge clk_i) begin
      if (rdy[1 + j]) dacc_q[j + 1] <= nxt;
    end
  end

  // Result register
  assign diff = (Q_W+1)'(ONE_Q14) - (Q_W+1)'(dacc_q[DV_STG].quo);

  always_ff @(posedge clk_i) begin
    if (rdy[NST-1]) begin
      if (info_i.norm == '0) begin
        proj_q   <= '0;
        status_q <= ST_ZERO;
      end else if (dacc_q[DV_STG].sat) begin
        proj_q   <= PROJ_MIN;
        status_q <= ST_SAT;
      end else begin
        proj_q   <= diff[PROJ_W-1:0];
        status_q <= ST_OK;
      end
    end
  end

  assign out_valid_o  = v_q[NST-1];
  assign projection_o = proj_q;
  assign status_o     = status_q;

endmodule

/* rtl/core/distance_projection_map.sv */
// Top level of the distance projection map: config port, distance and quotient pipelines.
//
//   channel  direction  handshake               payload
//   pixel    in         in_valid_i / in_stall_o pixel_row_i, pixel_col_i
//   result   out        out_valid_o/out_stall_i projection_o, status_o
//   config   in         psel, penable, pready   paddr, pwdata, prdata
//
// One pixel per cycle when neither stalled nor held; 12 distance stages, 10 quotient stages.
// The normalizer is the minimum corner distance; after each register write the corner
// sequencer (square, sum, 18 root steps, compare per corner, then one limit multiply)
// holds the pixel input until it is done. After reset the normalizer is zero until a write.
// Each pipeline stage loads whenever it or a later stage holds a bubble, so a stalled
// output keeps accepting pixels until the pipeline is full.
module distance_projection_map (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [dpm_pkg::PIX_W-1:0]    pixel_row_i,
  input  logic [dpm_pkg::PIX_W-1:0]    pixel_col_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dpm_pkg::PROJ_W-1:0]   projection_o,
  output logic [dpm_pkg::STAT_W-1:0]   status_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dpm_pkg::PADDR_W-1:0]  paddr,
  input  logic [dpm_pkg::APB_W-1:0]    pwdata,
  output logic [dpm_pkg::APB_W-1:0]    prdata,
  output logic                         pready
);
  import dpm_pkg::*;

  norm_info_t        info;
  logic              dist_in_valid, dist_in_stall;
  logic              dist_valid, div_stall;
  logic [ROOT_W-1:0] pix_dist;

  dpm_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .info_o  (info)
  );

  // Pixels wait while the normalizer is written or recomputed
  assign dist_in_valid = in_valid_i & ~info.hold;
  assign in_stall_o    = dist_in_stall | info.hold;

  dpm_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dist_in_valid),
    .in_stall_o  (dist_in_stall),
    .pixel_row_i (pixel_row_i),
    .pixel_col_i (pixel_col_i),
    .info_i      (info),
    .out_valid_o (dist_valid),
    .out_stall_i (div_stall),
    .dist_o      (pix_dist)
  );

  dpm_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (dist_valid),
    .in_stall_o   (div_stall),
    .dist_i       (pix_dist),
    .info_i       (info),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .projection_o (projection_o),
    .status_o     (status_o)
  );

endmodule

/* bench/tb_distance_projection_map.sv */
// Self-checking bench for distance_projection_map: directed and random pixel streams.
module tb_distance_projection_map;
  import dpm_pkg::*;

  localparam int CLK_HI      = 6;
  localparam int CLK_LO      = 6;
  localparam int RESET_CYC   = 7;
  localparam int DRAIN_CYC   = 30;
  localparam int TIMEOUT_CYC = 400000;
  localparam int RANDOM_ITEMS = 500;
  localparam int PHASE_ITEMS = 50;

  typedef struct {
    logic [PROJ_W-1:0] proj;
    status_e           status;
  } projection_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [PIX_W-1:0]    pixel_row_i;
  logic [PIX_W-1:0]    pixel_col_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [PROJ_W-1:0]   projection_o;
  logic [STAT_W-1:0]   status_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [APB_W-1:0]    pwdata;
  logic [APB_W-1:0]    prdata;
  logic                pready;

  // Shadow copy of the block configuration and its normalizer
  logic [SIDE_W-1:0]   cfg_height;
  logic [SIDE_W-1:0]   cfg_width;
  logic [CTR_W-1:0]    cfg_crow;
  logic [CTR_W-1:0]    cfg_ccol;
  logic [17:0]         norm_q4;

  projection_t         pending_projections[$];
  int                  mismatches;
  bit                  idle_on;

  distance_projection_map DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_row_i  (pixel_row_i),
    .pixel_col_i  (pixel_col_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .projection_o (projection_o),
    .status_o     (status_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #CLK_HI;
    clk_i = 1'b0;
    #CLK_LO;
  end

  // Integer square root, floor, digit by digit
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Distance in Q14.4 from integer point (r, c) to the center, capped at 18 bits
  function automatic longint unsigned center_distance(longint unsigned r, longint unsigned c);
    longint unsigned pr, pc, dr, dc, s;
    pr = r * 16;
    pc = c * 16;
    dr = (pr > cfg_crow) ? pr - cfg_crow : cfg_crow - pr;
    dc = (pc > cfg_ccol) ? pc - cfg_ccol : cfg_ccol - pc;
    s  = int_sqrt(dr * dr + dc * dc);
    if (s > 18'h3FFFF) s = 18'h3FFFF;
    return s;
  endfunction

  // Normalizer: nearest of the four corners, sides clamped to MAX_SIDE
  function automatic logic [17:0] nearest_corner();
    longint unsigned h, w, m, t;
    h = (cfg_height > MAX_SIDE) ? MAX_SIDE : cfg_height;
    w = (cfg_width > MAX_SIDE) ? MAX_SIDE : cfg_width;
    m = center_distance(0, 0);
    t = center_distance(0, w);
    if (t < m) m = t;
    t = center_distance(h, w);
    if (t < m) m = t;
    t = center_distance(h, 0);
    if (t < m) m = t;
    return m[17:0];
  endfunction

  // Expected result for one pixel under the current shadow configuration
  function automatic projection_t project_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] c);
    longint unsigned d, q, n;
    projection_t     e;
    n = norm_q4;
    if (n == 0) begin
      e.proj   = '0;
      e.status = ST_ZERO;
      return e;
    end
    d = center_distance(r, c);
    q = (d * ONE_Q14 + n / 2) / n;
    if (q > SAT_Q) begin
      e.proj   = PROJ_MIN;
      e.status = ST_SAT;
    end else begin
      e.proj   = PROJ_W'(longint'(ONE_Q14) - longint'(q));
      e.status = ST_OK;
    end
    return e;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Send one pixel; the expectation is queued at the transfer edge
  task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] c);
    int gap;
    gap = gap_len();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    pixel_row_i <= r;
    pixel_col_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    pending_projections.push_back(project_pixel(r, c));
  endtask

  // Let every pending result come out, then let the pipeline settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_projections.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // Register write: setup then access phase; shadow copy follows
  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HEIGHT: cfg_height = value[SIDE_W-1:0];
      REG_WIDTH:  cfg_width  = value[SIDE_W-1:0];
      REG_CROW:   cfg_crow   = value[CTR_W-1:0];
      REG_CCOL:   cfg_ccol   = value[CTR_W-1:0];
      default: ;
    endcase
    norm_q4 = nearest_corner();
  endtask

  task automatic set_config(int unsigned h, int unsigned w, int unsigned cr, int unsigned cc);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_CROW, cr);
    write_reg(REG_CCOL, cc);
  endtask

  // Out of reset the normalizer is zero until the first write
  task automatic test_reset_normalizer();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd240, 12'd320);
    drain();
  endtask

  // Center one pixel below the origin: normalizer 16, exact -2 and saturation
  task automatic test_saturation();
    set_config(4096, 4096, 16, 0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd4, 12'd0);
    send_pixel(12'd5, 12'd0);
    send_pixel(12'd50, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain();
  endtask

  // Sizes above MAX_SIDE clamp, zero sizes stay zero, center on a corner
  task automatic test_size_extremes();
    set_config(8191, 8191, 16'hFFFF, 16'hFFFF);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    drain();
    set_config(0, 0, 16'h1230, 16'h0450);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd291, 12'd69);
    send_pixel(12'd2048, 12'd1024);
    drain();
    set_config(480, 640, 480 * 16, 640 * 16);
    send_pixel(12'd100, 12'd100);
    send_pixel(12'd479, 12'd639);
    drain();
    set_config(480, 640, 240 * 16 + 8, 320 * 16 + 7);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd240, 12'd320);
    send_pixel(12'd479, 12'd639);
    send_pixel(12'd2730, 12'd1365);
    drain();
  endtask

  function automatic int unsigned random_side();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 18) return $urandom_range(4097, 8191);
    if (r < 30) return $urandom_range(1, 16);
    return $urandom_range(1, 4096);
  endfunction

  // Random phases: fresh configuration, then a burst of pixels
  task automatic test_random_stream();
    int unsigned h, w, hs, ws, cr, cc, rmax, cmax;
    int sent, n, r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      h  = random_side();
      w  = random_side();
      hs = (h > MAX_SIDE) ? MAX_SIDE : h;
      ws = (w > MAX_SIDE) ? MAX_SIDE : w;
      r  = $urandom_range(0, 99);
      if (r < 25) begin
        // near a corner: small normalizer, frequent saturation
        cr = ($urandom_range(0, 1) ? hs * 16 : 0);
        cc = ($urandom_range(0, 1) ? ws * 16 : 0);
        cr = (cr > 40) ? cr - $urandom_range(0, 40) : cr + $urandom_range(0, 40);
        cc = (cc > 40) ? cc - $urandom_range(0, 40) : cc + $urandom_range(0, 40);
        if (cr > 65535) cr = 65535;
        if (cc > 65535) cc = 65535;
      end else if (r < 40) begin
        cr = $urandom_range(0, 65535);
        cc = $urandom_range(0, 65535);
      end else begin
        cr = $urandom_range(0, (hs * 16 > 65535) ? 65535 : hs * 16);
        cc = $urandom_range(0, (ws * 16 > 65535) ? 65535 : ws * 16);
      end
      // rewrite only some registers in some phases
      if (sent == 0 || $urandom_range(0, 1)) begin
        set_config(h, w, cr, cc);
      end else begin
        case ($urandom_range(0, 3))
          0: write_reg(REG_HEIGHT, h);
          1: write_reg(REG_WIDTH, w);
          2: write_reg(REG_CROW, cr);
          default: write_reg(REG_CCOL, cc);
        endcase
      end
      rmax = (cfg_height == 0) ? 0 : ((cfg_height > 4096) ? 4095 : cfg_height - 1);
      cmax = (cfg_width == 0) ? 0 : ((cfg_width > 4096) ? 4095 : cfg_width - 1);
      n = $urandom_range(PHASE_ITEMS / 2, PHASE_ITEMS * 3 / 2);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0)
          send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
        else
          send_pixel(PIX_W'($urandom_range(0, rmax)), PIX_W'($urandom_range(0, cmax)));
      end
      sent += n;
      drain();
    end
  endtask

  // Receiver stall pattern
  initial begin
    int run, stl;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(0, 20);
      repeat (run) @(negedge clk_i);
      stl = gap_len();
      if (stl > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (stl - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        @(negedge clk_i);
      end
    end
  end

  // Result checker: compare each transfer against the oldest expectation
  always @(posedge clk_i) begin
    projection_t exp_item;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_projections.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: projection %0d status %0d",
                   $signed(projection_o), status_o);
      end else begin
        exp_item = pending_projections.pop_front();
        if (projection_o !== exp_item.proj || status_o !== exp_item.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: projection exp %0d got %0d, status exp %0d got %0d",
                     $signed(exp_item.proj), $signed(projection_o),
                     exp_item.status, status_o);
        end
      end
    end
  end

  // Run limit
  initial begin
    #(TIMEOUT_CYC * (CLK_HI + CLK_LO));
    $display("end of test: mismatches");
    $finish;
  end

  // Test sequence
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    pixel_row_i = '0;
    pixel_col_i = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cfg_height  = SIDE_W'(H_RESET);
    cfg_width   = SIDE_W'(W_RESET);
    cfg_crow    = '0;
    cfg_ccol    = '0;
    norm_q4     = '0;
    mismatches  = 0;
    idle_on     = 1'b0;
    repeat (RESET_CYC) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_normalizer();
    idle_on = 1'b1;
    test_saturation();
    test_size_extremes();
    test_random_stream();

    mismatches += pending_projections.size();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/dpm_pkg.sv
rtl/core/dpm_norm.sv
rtl/core/dpm_dist.sv
rtl/core/dpm_div.sv
rtl/core/distance_projection_map.sv
bench/tb_distance_projection_map.sv
